// ----- hw/rtl/tfn_pkg.sv -----
// ----------------------------------------------------------------------------
// tfn_pkg
// Types and constants for the triangle face normal core.
// ----------------------------------------------------------------------------
package tfn_pkg;

	localparam int SQRT_STAGES = 32;
	localparam int DIV_STAGES  = 31;
	// front (6) + root + dividend + divide + sign + product + difference + output
	localparam int LATENCY     = 6 + SQRT_STAGES + 1 + DIV_STAGES + 4;

	localparam logic [63:0] ONE_Q30  = 64'd1073741824;
	localparam logic [63:0] HALF_Q30 = 64'd536870912;

	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] c_x;
		logic signed [31:0] c_y;
		logic signed [31:0] c_z;
	} vert_t;

	typedef struct packed {
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic               degenerate;
	} nrm_t;

endpackage

// ----- hw/rtl/tfn_if.sv -----
// ----------------------------------------------------------------------------
// tfn_if
// Valid/ready channels for vertex items and normal items.
// ----------------------------------------------------------------------------
interface tfn_vert_if;
	logic          valid;
	logic          ready;
	tfn_pkg::vert_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface tfn_norm_if;
	logic         valid;
	logic         ready;
	tfn_pkg::nrm_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/triangle_face_normal_core.sv -----
// ----------------------------------------------------------------------------
// triangle_face_normal_core
// Unit-edge cross product face normal, Q16.16 vertices in, Q2.30 normal out.
// ----------------------------------------------------------------------------
// Channels: vert carries one triangle (three Q16.16 vertices) per item, norm
// carries one Q2.30 normal and a degenerate flag per item. Both are
// valid/ready; an item moves on a rising edge with valid and ready high.
// The pipeline has six front stages (edges, magnitudes, bit length,
// normalise, squares, sum), 32 stages of the square-root recurrence (one
// root bit each), one dividend stage, 31 stages of restoring division (one
// quotient bit each), then sign, product, difference and rounding stages.
// Throughput is one item per cycle; a new item enters every cycle while
// norm is taken or the output register is empty.
// When the receiver holds norm.ready low with a result waiting, the whole
// pipeline freezes; nothing is lost or repeated, and bubbles still move
// forward while the output register is empty.
// Reset clears all valid bits; the pipeline is empty afterwards.
// An edge of zero length gives a zero normal with degenerate set.
// ----------------------------------------------------------------------------
module triangle_face_normal_core (
	input  logic            clk,
	input  logic            arst_n,
	tfn_vert_if.sink        vert,
	tfn_norm_if.source      norm
);
	import tfn_pkg::*;

	logic                adv;
	logic [LATENCY-1:0]  vld_q;

	assign adv        = norm.ready | ~vld_q[LATENCY-1];
	assign vert.ready = adv;
	assign norm.valid = vld_q[LATENCY-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LATENCY-2:0], vert.valid};
		end
	end

	// front stages
	logic        [1:0][2:0][32:0] e_s1;
	logic        [1:0][2:0][32:0] mag_s2;
	logic        [1:0][2:0]       neg_s2;
	logic        [1:0][2:0][32:0] mag_s3;
	logic        [1:0][2:0]       neg_s3;
	logic        [1:0][5:0]       bl_s3;
	logic        [1:0]            zero_s3;
	logic        [1:0][2:0][30:0] nm_s4;
	logic        [1:0][2:0]       neg_s4;
	logic        [1:0]            zero_s4;
	logic        [1:0][2:0][61:0] sq_s5;
	logic        [1:0][2:0][30:0] nm_s5;
	logic        [1:0][2:0]       neg_s5;
	logic        [1:0]            zero_s5;
	logic        [1:0][63:0]      sum_s6;
	logic        [1:0][2:0][30:0] nm_s6;
	logic        [1:0][2:0]       neg_s6;
	logic        [1:0]            zero_s6;

	logic [1:0][2:0][32:0] mag_c;
	logic [1:0][2:0]       neg_c;
	logic [1:0][32:0]      mx_c;
	logic [1:0][5:0]       bl_c;
	logic [1:0][2:0][30:0] nm_c;

	always_comb begin
		for (int e = 0; e < 2; e++) begin
			for (int i = 0; i < 3; i++) begin
				neg_c[e][i] = e_s1[e][i][32];
				mag_c[e][i] = e_s1[e][i][32] ? 33'(-e_s1[e][i]) : e_s1[e][i];
			end
			mx_c[e] = mag_s2[e][0];
			if (mag_s2[e][1] > mx_c[e]) mx_c[e] = mag_s2[e][1];
			if (mag_s2[e][2] > mx_c[e]) mx_c[e] = mag_s2[e][2];
			bl_c[e] = '0;
			for (int k = 0; k < 33; k++) begin
				if (mx_c[e][k]) bl_c[e] = 6'(k + 1);
			end
			for (int i = 0; i < 3; i++) begin
				if (bl_s3[e] > 6'd31)
					nm_c[e][i] = 31'(mag_s3[e][i] >> (bl_s3[e] - 6'd31));
				else
					nm_c[e][i] = 31'(mag_s3[e][i] << (6'd31 - bl_s3[e]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s1[0][0] <= 33'($signed(vert.data.b_x)) - 33'($signed(vert.data.a_x));
			e_s1[0][1] <= 33'($signed(vert.data.b_y)) - 33'($signed(vert.data.a_y));
			e_s1[0][2] <= 33'($signed(vert.data.b_z)) - 33'($signed(vert.data.a_z));
			e_s1[1][0] <= 33'($signed(vert.data.c_x)) - 33'($signed(vert.data.a_x));
			e_s1[1][1] <= 33'($signed(vert.data.c_y)) - 33'($signed(vert.data.a_y));
			e_s1[1][2] <= 33'($signed(vert.data.c_z)) - 33'($signed(vert.data.a_z));
			mag_s2  <= mag_c;
			neg_s2  <= neg_c;
			mag_s3  <= mag_s2;
			neg_s3  <= neg_s2;
			bl_s3   <= bl_c;
			for (int e = 0; e < 2; e++) begin
				zero_s3[e] <= (mx_c[e] == '0);
				for (int i = 0; i < 3; i++) begin
					sq_s5[e][i] <= 62'(nm_s4[e][i]) * 62'(nm_s4[e][i]);
				end
				sum_s6[e] <= 64'(sq_s5[e][0]) + 64'(sq_s5[e][1]) + 64'(sq_s5[e][2]);
			end
			nm_s4   <= nm_c;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
			nm_s5   <= nm_s4;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
			nm_s6   <= nm_s5;
			neg_s6  <= neg_s5;
			zero_s6 <= zero_s5;
		end
	end

	// square root, one root bit per stage
	logic [1:0][63:0]      sq_x_s    [SQRT_STAGES+1];
	logic [1:0][33:0]      sq_rem_s  [SQRT_STAGES+1];
	logic [1:0][31:0]      sq_root_s [SQRT_STAGES+1];
	logic [1:0][2:0][30:0] sq_nm_s   [SQRT_STAGES+1];
	logic [1:0][2:0]       sq_neg_s  [SQRT_STAGES+1];
	logic [1:0]            sq_zero_s [SQRT_STAGES+1];

	assign sq_x_s[0]    = sum_s6;
	assign sq_rem_s[0]  = '0;
	assign sq_root_s[0] = '0;
	assign sq_nm_s[0]   = nm_s6;
	assign sq_neg_s[0]  = neg_s6;
	assign sq_zero_s[0] = zero_s6;

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
		logic [1:0][35:0] trial;
		logic [1:0][35:0] sub;
		always_comb begin
			for (int e = 0; e < 2; e++) begin
				trial[e] = {sq_rem_s[k][e], sq_x_s[k][e][63-2*k -: 2]};
				sub[e]   = {2'b00, sq_root_s[k][e], 2'b01};
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int e = 0; e < 2; e++) begin
					if (trial[e] >= sub[e]) begin
						sq_rem_s[k+1][e]  <= 34'(trial[e] - sub[e]);
						sq_root_s[k+1][e] <= {sq_root_s[k][e][30:0], 1'b1};
					end else begin
						sq_rem_s[k+1][e]  <= trial[e][33:0];
						sq_root_s[k+1][e] <= {sq_root_s[k][e][30:0], 1'b0};
					end
				end
				sq_x_s[k+1]    <= sq_x_s[k];
				sq_nm_s[k+1]   <= sq_nm_s[k];
				sq_neg_s[k+1]  <= sq_neg_s[k];
				sq_zero_s[k+1] <= sq_zero_s[k];
			end
		end
	end

	// dividend: nm * 2^30 + len / 2
	logic [1:0][2:0][31:0] dv_rem_s  [DIV_STAGES+1];
	logic [1:0][2:0][30:0] dv_low_s  [DIV_STAGES+1];
	logic [1:0][2:0][30:0] dv_q_s    [DIV_STAGES+1];
	logic [1:0][31:0]      dv_len_s  [DIV_STAGES+1];
	logic [1:0][2:0]       dv_neg_s  [DIV_STAGES+1];
	logic [1:0]            dv_zero_s [DIV_STAGES+1];

	logic [1:0][2:0][61:0] num_c;
	always_comb begin
		for (int e = 0; e < 2; e++) begin
			for (int i = 0; i < 3; i++) begin
				num_c[e][i] = {1'b0, sq_nm_s[SQRT_STAGES][e][i], 30'b0}
					+ 62'(sq_root_s[SQRT_STAGES][e] >> 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int e = 0; e < 2; e++) begin
				for (int i = 0; i < 3; i++) begin
					dv_rem_s[0][e][i] <= {1'b0, num_c[e][i][61:31]};
					dv_low_s[0][e][i] <= num_c[e][i][30:0];
				end
			end
			dv_q_s[0]    <= '0;
			dv_len_s[0]  <= sq_root_s[SQRT_STAGES];
			dv_neg_s[0]  <= sq_neg_s[SQRT_STAGES];
			dv_zero_s[0] <= sq_zero_s[SQRT_STAGES];
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
		logic [1:0][2:0][32:0] part;
		always_comb begin
			for (int e = 0; e < 2; e++) begin
				for (int i = 0; i < 3; i++) begin
					part[e][i] = {dv_rem_s[j][e][i], dv_low_s[j][e][i][DIV_STAGES-1-j]};
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int e = 0; e < 2; e++) begin
					for (int i = 0; i < 3; i++) begin
						if (part[e][i] >= {1'b0, dv_len_s[j][e]}) begin
							dv_rem_s[j+1][e][i] <= 32'(part[e][i] - {1'b0, dv_len_s[j][e]});
							dv_q_s[j+1][e][i]   <= {dv_q_s[j][e][i][29:0], 1'b1};
						end else begin
							dv_rem_s[j+1][e][i] <= part[e][i][31:0];
							dv_q_s[j+1][e][i]   <= {dv_q_s[j][e][i][29:0], 1'b0};
						end
					end
				end
				dv_low_s[j+1]  <= dv_low_s[j];
				dv_len_s[j+1]  <= dv_len_s[j];
				dv_neg_s[j+1]  <= dv_neg_s[j];
				dv_zero_s[j+1] <= dv_zero_s[j];
			end
		end
	end

	// signed unit edges, cross product, rounding
	logic signed [1:0][2:0][31:0] u_s;
	logic                         dg_u_s;
	logic signed [5:0][63:0]      p_s;
	logic                         dg_p_s;
	logic signed [2:0][63:0]      d_s;
	logic                         dg_d_s;
	nrm_t                         out_q;

	logic [2:0][63:0] dmag_c;
	logic [2:0][63:0] rnd_c;
	logic [2:0][31:0] nv_c;
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			dmag_c[a] = d_s[a][63] ? 64'(-d_s[a]) : 64'(d_s[a]);
			rnd_c[a]  = (dmag_c[a] + HALF_Q30) >> 30;
			if (rnd_c[a] > ONE_Q30) rnd_c[a] = ONE_Q30;
			nv_c[a]   = d_s[a][63] ? 32'(-rnd_c[a]) : rnd_c[a][31:0];
			if (dg_d_s) nv_c[a] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int e = 0; e < 2; e++) begin
				for (int i = 0; i < 3; i++) begin
					u_s[e][i] <= dv_neg_s[DIV_STAGES][e][i]
						? 32'(-{1'b0, dv_q_s[DIV_STAGES][e][i]})
						: {1'b0, dv_q_s[DIV_STAGES][e][i]};
				end
			end
			dg_u_s <= dv_zero_s[DIV_STAGES][0] | dv_zero_s[DIV_STAGES][1];
			p_s[0] <= $signed(u_s[0][1]) * $signed(u_s[1][2]);
			p_s[1] <= $signed(u_s[0][2]) * $signed(u_s[1][1]);
			p_s[2] <= $signed(u_s[0][2]) * $signed(u_s[1][0]);
			p_s[3] <= $signed(u_s[0][0]) * $signed(u_s[1][2]);
			p_s[4] <= $signed(u_s[0][0]) * $signed(u_s[1][1]);
			p_s[5] <= $signed(u_s[0][1]) * $signed(u_s[1][0]);
			dg_p_s <= dg_u_s;
			d_s[0] <= p_s[0] - p_s[1];
			d_s[1] <= p_s[2] - p_s[3];
			d_s[2] <= p_s[4] - p_s[5];
			dg_d_s <= dg_p_s;
			out_q.normal_x   <= nv_c[0];
			out_q.normal_y   <= nv_c[1];
			out_q.normal_z   <= nv_c[2];
			out_q.degenerate <= dg_d_s;
		end
	end

	assign norm.data = out_q;

`ifndef SYNTHESIS
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		norm.valid && norm.data.degenerate |->
		norm.data.normal_x == '0 && norm.data.normal_y == '0 && norm.data.normal_z == '0)
		else $error("degenerate item with non-zero normal");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		norm.valid |->
		$signed(norm.data.normal_x) <= 32'sd1073741824 &&
		$signed(norm.data.normal_x) >= -32'sd1073741824 &&
		$signed(norm.data.normal_y) <= 32'sd1073741824 &&
		$signed(norm.data.normal_y) >= -32'sd1073741824 &&
		$signed(norm.data.normal_z) <= 32'sd1073741824 &&
		$signed(norm.data.normal_z) >= -32'sd1073741824)
		else $error("normal component out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline moved during stall");
`endif

endmodule
